// ----- rtl/core/arp_cache_with_ttl_aging_macros.svh -----
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_TTL_AGING_MACROS_SVH
`define ARP_CACHE_WITH_TTL_AGING_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that an expression is never true outside reset
`define ARPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/core/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Command, outcome and register codes, protocol constants and reset values.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_FRAME  = 2'd2;

	localparam logic [2:0] OUT_TICK_DONE = 3'd0;
	localparam logic [2:0] OUT_NOT_ARP   = 3'd1;
	localparam logic [2:0] OUT_ARP_DONE  = 3'd2;
	localparam logic [2:0] OUT_REPLY     = 3'd3;
	localparam logic [2:0] OUT_HIT       = 3'd4;
	localparam logic [2:0] OUT_MISS      = 3'd5;

	localparam logic [1:0] CFG_LOCAL_IP      = 2'd0;
	localparam logic [1:0] CFG_LOCAL_MAC     = 2'd1;
	localparam logic [1:0] CFG_TICKS_PER_AGE = 2'd2;
	localparam logic [1:0] CFG_MAX_TTL       = 2'd3;

	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [7:0]  OP_REQUEST    = 8'h01;
	localparam logic [7:0]  OP_REPLY      = 8'h02;
	localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

	localparam logic [15:0] RST_TICKS_PER_AGE = 16'd60000;
	localparam logic [14:0] RST_MAX_TTL       = 15'd10;
	localparam logic [15:0] RST_TTL           = 16'hFEFE;
	localparam logic [31:0] RST_IP            = 32'hFEFE_FEFE;
	localparam logic [47:0] RST_MAC           = 48'hFEFE_FEFE_FEFE;

endpackage

// ----- rtl/core/arp_cache_with_ttl_aging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache with TTL aging
// IP-to-MAC table with signed time-to-live per entry, timer aging, lookup,
// reply learning and local request answering, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Usage: present a command with start high; it is taken on a clock edge where
// busy is low. Every transaction yields exactly one result, shown on outcome,
// mac_out and ip_out for a single cycle while done is high. There is no way
// to hold a result off: capture it in the cycle that done is high. A tick that
// does not end the aging period, a frame that is not ARP and any ARP frame
// other than a reply give their result on the cycle after start and never
// raise busy. Work that touches the table goes through one entry comparator,
// which reads one entry per cycle: a tick that ends the aging period visits
// every entry, a lookup scans down from the top entry to the first live entry
// holding the key or through entry 0 on a miss, and an ARP reply scans to an
// entry with the same IP or through entry 0, then writes the chosen entry.
// Configuration writes are always accepted (cfg_ready is tied high) and belong only in idle periods.
// ----------------------------------------------------------------------------
`include "arp_cache_with_ttl_aging_macros.svh"

module arp_cache_with_ttl_aging
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] lookup_ip,
	input  logic [15:0] ether_type,
	input  logic [7:0]  opcode_low,
	input  logic [47:0] frame_src_mac,
	input  logic [47:0] sender_mac,
	input  logic [31:0] sender_ip,
	input  logic [31:0] target_ip,
	// result strobe
	output logic        done,
	output logic [2:0]  outcome,
	output logic [47:0] mac_out,
	output logic [31:0] ip_out,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AGE,
		ST_LOOKUP,
		ST_LEARN,
		ST_LEARN_WR
	} state_t;

	// Configuration registers
	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic [15:0] ticks_per_age_q;
	logic [14:0] max_ttl_q;

	// Table storage
	logic signed [15:0] entry_ttl_q [TABLE_ENTRIES];
	logic [31:0]        entry_ip_q  [TABLE_ENTRIES];
	logic [47:0]        entry_mac_q [TABLE_ENTRIES];

	// Sequencer state
	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [15:0]        age_q;
	logic [31:0]        key_q;
	logic [47:0]        store_mac_q;
	logic signed [15:0] lowest_q;
	logic [IDX_W-1:0]   chosen_q;
	logic               chosen_vld_q;

	// Registered result
	logic        done_q;
	logic [2:0]  outcome_q;
	logic [47:0] mac_out_q;
	logic [31:0] ip_out_q;

	// Shared entry compare unit
	logic signed [15:0] cur_ttl;
	logic [47:0]        cur_mac;
	logic               ip_eq;
	logic               live;
	logic               last;
	logic               below;
	logic signed [15:0] ttl_reload;
	logic [15:0]        age_dec;

	// Table write port
	logic               we_ttl;
	logic               we_pair;
	logic [IDX_W-1:0]   wa;
	logic signed [15:0] wd_ttl;

	logic accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign outcome   = outcome_q;
	assign mac_out   = mac_out_q;
	assign ip_out    = ip_out_q;

	// Read the entry under the scan index and compare it once per cycle
	always_comb begin
		cur_ttl    = entry_ttl_q[idx_q];
		cur_mac    = entry_mac_q[idx_q];
		ip_eq      = (entry_ip_q[idx_q] == key_q);
		live       = (cur_ttl > 16'sd0);
		below      = (cur_ttl <= lowest_q);
		last       = (idx_q == '0);
		ttl_reload = $signed({1'b0, max_ttl_q});
		age_dec    = age_q - 16'd1;
	end

	// Select the single table write of this cycle
	always_comb begin
		we_ttl  = 1'b0;
		we_pair = 1'b0;
		wa      = idx_q;
		wd_ttl  = ttl_reload;
		case (state_q)
			ST_AGE: begin
				we_ttl = live;
				wd_ttl = cur_ttl - 16'sd1;
			end
			ST_LOOKUP: begin
				we_ttl = ip_eq && live;
			end
			ST_LEARN_WR: begin
				we_ttl  = chosen_vld_q;
				we_pair = chosen_vld_q;
				wa      = chosen_q;
			end
			default: begin
				we_ttl = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q      <= '0;
			local_mac_q     <= '0;
			ticks_per_age_q <= RST_TICKS_PER_AGE;
			max_ttl_q       <= RST_MAX_TTL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOCAL_IP:      local_ip_q      <= cfg_data[31:0];
				CFG_LOCAL_MAC:     local_mac_q     <= cfg_data;
				CFG_TICKS_PER_AGE: ticks_per_age_q <= cfg_data[15:0];
				CFG_MAX_TTL:       max_ttl_q       <= cfg_data[14:0];
				default:           local_ip_q      <= local_ip_q;
			endcase
		end
	end

	// Table entries, reset to the invalid pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				entry_ttl_q[i] <= RST_TTL;
				entry_ip_q[i]  <= RST_IP;
				entry_mac_q[i] <= RST_MAC;
			end
		end else begin
			if (we_ttl) begin
				entry_ttl_q[wa] <= wd_ttl;
			end
			if (we_pair) begin
				entry_ip_q[wa]  <= key_q;
				entry_mac_q[wa] <= store_mac_q;
			end
		end
	end

	// Sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			age_q        <= RST_TICKS_PER_AGE;
			key_q        <= '0;
			store_mac_q  <= '0;
			lowest_q     <= '0;
			chosen_q     <= '0;
			chosen_vld_q <= 1'b0;
			done_q       <= 1'b0;
			outcome_q    <= OUT_TICK_DONE;
			mac_out_q    <= '0;
			ip_out_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q     <= IDX_TOP;
						outcome_q <= OUT_TICK_DONE;
						mac_out_q <= '0;
						ip_out_q  <= '0;
						case (command)
							CMD_TICK: begin
								// Reload on expiry, then age every entry
								if (age_dec == 16'd0) begin
									age_q   <= ticks_per_age_q;
									state_q <= ST_AGE;
								end else begin
									age_q  <= age_dec;
									done_q <= 1'b1;
								end
							end
							CMD_LOOKUP: begin
								key_q   <= lookup_ip;
								state_q <= ST_LOOKUP;
							end
							CMD_FRAME: begin
								if (ether_type != ETHERTYPE_ARP) begin
									outcome_q <= OUT_NOT_ARP;
									done_q    <= 1'b1;
								end else if (opcode_low == OP_REPLY) begin
									key_q        <= sender_ip;
									store_mac_q  <= sender_mac;
									lowest_q     <= ttl_reload;
									chosen_vld_q <= 1'b0;
									state_q      <= ST_LEARN;
								end else if (opcode_low == OP_REQUEST &&
								             target_ip == local_ip_q) begin
									outcome_q <= OUT_REPLY;
									mac_out_q <= frame_src_mac;
									ip_out_q  <= sender_ip;
									done_q    <= 1'b1;
								end else begin
									outcome_q <= OUT_ARP_DONE;
									done_q    <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_AGE: begin
					idx_q <= idx_q - 1'b1;
					if (last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_LOOKUP: begin
					idx_q <= idx_q - 1'b1;
					if (ip_eq && live) begin
						outcome_q <= OUT_HIT;
						mac_out_q <= cur_mac;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (last) begin
						outcome_q <= OUT_MISS;
						mac_out_q <= MAC_BCAST;
						ip_out_q  <= key_q;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_LEARN: begin
					idx_q <= idx_q - 1'b1;
					if (ip_eq) begin
						// Same IP wins outright
						chosen_q     <= idx_q;
						chosen_vld_q <= 1'b1;
						state_q      <= ST_LEARN_WR;
					end else begin
						// Lowest TTL so far, ties going to the lower index
						if (below) begin
							lowest_q     <= cur_ttl;
							chosen_q     <= idx_q;
							chosen_vld_q <= 1'b1;
						end
						if (last) begin
							state_q <= ST_LEARN_WR;
						end
					end
				end
				ST_LEARN_WR: begin
					outcome_q <= OUT_ARP_DONE;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ARPC_ASSERT(a_done_follows_work, clk, arst_n, done |-> ($past(busy) || $past(start)), "result without a transaction")
	`ARPC_ASSERT_NEVER(a_done_not_busy, clk, arst_n, done && busy, "result shown while still busy")
	`ARPC_ASSERT(a_busy_from_accept, clk, arst_n, $rose(busy) |-> $past(start), "busy rose without a start")
	`ARPC_ASSERT(a_idx_in_range, clk, arst_n, busy |-> (int'(idx_q) < TABLE_ENTRIES), "scan index beyond the table")

endmodule
